// File: sv/ffha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants
// Geometry, codes and the extent/cell-control types of the first-fit heap
// allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES       = 65536;
  localparam int MAX_FREE_EXTENTS = 64;
  localparam int HEADER_BYTES     = 16;
  localparam int ALIGN_BYTES      = 8;
  localparam int TAG_DEPTH        = HEAP_BYTES / ALIGN_BYTES;

  localparam int OFF_W    = $clog2(HEAP_BYTES);
  localparam int SIZE_W   = OFF_W + 1;
  localparam int IDX_W    = $clog2(MAX_FREE_EXTENTS + 1);
  localparam int SCAN_W   = $clog2(MAX_FREE_EXTENTS);
  localparam int TAG_AW   = $clog2(TAG_DEPTH);
  localparam int ALIGN_SH = $clog2(ALIGN_BYTES);

  // port widths
  localparam int ACTION_W = 2;
  localparam int REQ_W    = 17;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 2;
  localparam int BLK_W    = REQ_W + 1;

  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } extent_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             init;     // load the single whole-heap extent
    logic             rot;      // every cell takes its right neighbor
    logic             rep;      // overwrite cell rep_idx with ent
    logic             ins;      // open a hole at mod_idx, fill with ent
    logic             rm;       // close the hole at mod_idx
    logic [IDX_W-1:0] rep_idx;
    logic [IDX_W-1:0] mod_idx;
    extent_t          ent;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: sv/ffha_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/ffha_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_cell: one free-extent slot
// Holds one extent; rotates, shifts for insert/remove or is overwritten.
// ----------------------------------------------------------------------------
module ffha_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [ffha_pkg::IDX_W-1:0] my_idx,
  input  wire ffha_pkg::cell_ctl_t        ctl,
  input  wire ffha_pkg::extent_t          left_ent,
  input  wire ffha_pkg::extent_t          right_ent,
  output ffha_pkg::extent_t               ent
);
  import ffha_pkg::*;

  extent_t ent_r;
  extent_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.init) begin
      ent_nxt = (my_idx == '0) ? ctl.ent : '0;
    end else if (ctl.rot) begin
      ent_nxt = right_ent;
    end else if (ctl.rep && my_idx == ctl.rep_idx) begin
      ent_nxt = ctl.ent;
    end else if (ctl.ins && my_idx == ctl.mod_idx) begin
      ent_nxt = ctl.ent;
    end else if (ctl.ins && my_idx > ctl.mod_idx) begin
      ent_nxt = left_ent;
    end else if (ctl.rm && my_idx >= ctl.mod_idx) begin
      ent_nxt = right_ent;
    end
  end

  // only the valid bit needs a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.off  <= ent_nxt.off;
    ent_r.size <= ent_nxt.size;
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

// File: sv/first_fit_heap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap allocator with coalescing free
// Address-ordered free-extent list kept in a chain of cells, plus a
// size-tag RAM for the allocated blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_action / in_request_bytes / in_block_address with start;
//   the word is taken on a clock edge where start is high and busy is low.
//   Output: one result word per input word, shown for one cycle with
//   out_valid high (out_status, out_granted_address). The receiver cannot
//   hold it off; it must take it in that cycle.
// Sequencing (MAX_FREE_EXTENTS = N cells):
//   init, unused action, free before init or below the header: answered
//   without a search. allocate searches the chain; free first reads the tag
//   RAM, then searches. busy stays high for the whole item, so items follow
//   one another. In the search the chain rotates once through all N cells
//   so the head cell is examined in order, then the edit step shifts,
//   inserts or overwrites cells in parallel.
// Reset: synchronous, active-low rst_n. The heap comes up uninitialized;
//   the first allocate (or an init) loads one free extent spanning the heap.
//   The tag RAM is not cleared.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ffha_pkg::ACTION_W-1:0] in_action,
  input  wire logic [ffha_pkg::REQ_W-1:0]    in_request_bytes,
  input  wire logic [ffha_pkg::ADDR_W-1:0]   in_block_address,
  output logic                               out_valid,
  output logic [ffha_pkg::STATUS_W-1:0]      out_status,
  output logic [ffha_pkg::ADDR_W-1:0]        out_granted_address
);
  import ffha_pkg::*;

  localparam int N = MAX_FREE_EXTENTS;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_TAG    = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic              heap_ready_r, heap_ready_nxt;
  logic [IDX_W-1:0]  count_r, count_nxt;
  logic [SCAN_W-1:0] k_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_granted_r;

  // latched item
  logic [ACTION_W-1:0] act_r;
  logic [BLK_W-1:0]    blk_r;       // allocate: rounded size incl. header
  logic [OFF_W-1:0]    h_r;         // free: header offset

  // pass results
  logic              found_r;
  logic [IDX_W-1:0]  fi_r;
  logic [OFF_W-1:0]  foff_r;
  logic [SIZE_W-1:0] fsize_r;
  logic              left_v_r;
  logic [OFF_W-1:0]  left_off_r;
  logic [SIZE_W-1:0] left_size_r;
  logic              right_v_r;
  logic [IDX_W-1:0]  pos_r;
  logic [OFF_W-1:0]  right_off_r;
  logic [SIZE_W-1:0] right_size_r;
  logic              ovl_r;

  logic accept;
  assign accept = start && !busy;

  // -------------------------------------------------------------------------
  // cell chain
  // -------------------------------------------------------------------------
  cell_ctl_t ctl;
  extent_t   cell_q [N];
  extent_t   head;
  extent_t   tail_in;

  assign head    = cell_q[0];
  assign tail_in = ctl.rot ? head : '0;   // rotate, or pull in an empty slot

  for (genvar i = 0; i < N; i++) begin : g_cell
    extent_t lft, rgt;
    if (i == 0) begin : g_first
      assign lft = '0;
    end else begin : g_mid_l
      assign lft = cell_q[i-1];
    end
    if (i == N - 1) begin : g_last
      assign rgt = tail_in;
    end else begin : g_mid_r
      assign rgt = cell_q[i+1];
    end
    ffha_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .my_idx    (IDX_W'(i)),
      .ctl       (ctl),
      .left_ent  (lft),
      .right_ent (rgt),
      .ent       (cell_q[i])
    );
  end

  // -------------------------------------------------------------------------
  // size-tag RAM, indexed by header offset / 8
  // -------------------------------------------------------------------------
  logic              tag_we;
  logic [TAG_AW-1:0] tag_waddr;
  logic [SIZE_W-1:0] tag_wdata;
  logic [SIZE_W-1:0] tag_rdata;

  ffha_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (h_r[OFF_W-1:ALIGN_SH]),
    .rdata (tag_rdata)
  );

  // -------------------------------------------------------------------------
  // request decode at accept
  // -------------------------------------------------------------------------
  logic [BLK_W-1:0] in_blk;
  logic             need_init;
  logic             free_ok;

  always_comb begin
    logic [BLK_W-1:0] pay;
    pay = (BLK_W'(in_request_bytes) + BLK_W'(ALIGN_BYTES - 1))
          & ~BLK_W'(ALIGN_BYTES - 1);
    if (in_request_bytes == '0) begin
      pay = BLK_W'(ALIGN_BYTES);
    end
    in_blk = pay + BLK_W'(HEADER_BYTES);
  end

  assign need_init = accept && (in_action == ACT_INIT ||
                                (in_action == ACT_ALLOC && !heap_ready_r));
  assign free_ok   = heap_ready_r && (in_block_address >= ADDR_W'(HEADER_BYTES));

  // -------------------------------------------------------------------------
  // edit decision, taken after the search pass
  // -------------------------------------------------------------------------
  logic              exact;
  logic              bad_free;
  logic              adj_l, adj_r;
  logic [IDX_W-1:0]  pos;
  logic [STATUS_W-1:0] dec_status;

  assign exact = (BLK_W'(fsize_r) == blk_r);
  assign bad_free = ovl_r || (tag_rdata == '0) ||
                    (BLK_W'(tag_rdata) > BLK_W'(HEAP_BYTES) - BLK_W'(h_r));
  assign adj_l = left_v_r &&
                 (BLK_W'(left_off_r) + BLK_W'(left_size_r) == BLK_W'(h_r));
  assign adj_r = right_v_r &&
                 (BLK_W'(h_r) + BLK_W'(tag_rdata) == BLK_W'(right_off_r));
  assign pos   = right_v_r ? pos_r : count_r;

  always_comb begin
    ctl        = '0;
    tag_we     = 1'b0;
    tag_waddr  = h_r[OFF_W-1:ALIGN_SH];
    tag_wdata  = '0;
    count_nxt  = count_r;
    dec_status = ST_DONE;
    if (need_init) begin
      ctl.init  = 1'b1;
      ctl.ent   = '{valid: 1'b1, off: '0, size: SIZE_W'(HEAP_BYTES)};
      count_nxt = IDX_W'(1);
    end else if (state_r == S_SCAN) begin
      ctl.rot = 1'b1;
    end else if (state_r == S_DECIDE) begin
      case (act_r)
        ACT_ALLOC: begin
          if (!found_r) begin
            dec_status = ST_NOFIT;
          end else begin
            dec_status = ST_OK;
            tag_we     = 1'b1;
            tag_waddr  = foff_r[OFF_W-1:ALIGN_SH];
            tag_wdata  = blk_r[SIZE_W-1:0];
            if (exact) begin
              ctl.rm      = 1'b1;
              ctl.mod_idx = fi_r;
              count_nxt   = count_r - IDX_W'(1);
            end else begin
              ctl.rep     = 1'b1;
              ctl.rep_idx = fi_r;
              ctl.ent     = '{valid: 1'b1,
                              off:   foff_r + blk_r[OFF_W-1:0],
                              size:  fsize_r - blk_r[SIZE_W-1:0]};
            end
          end
        end
        ACT_FREE: begin
          if (!bad_free) begin
            tag_we = 1'b1;
            if (adj_l && adj_r) begin
              ctl.rep     = 1'b1;
              ctl.rep_idx = pos - IDX_W'(1);
              ctl.rm      = 1'b1;
              ctl.mod_idx = pos;
              ctl.ent     = '{valid: 1'b1, off: left_off_r,
                              size: left_size_r + tag_rdata + right_size_r};
              count_nxt   = count_r - IDX_W'(1);
            end else if (adj_l) begin
              ctl.rep     = 1'b1;
              ctl.rep_idx = pos - IDX_W'(1);
              ctl.ent     = '{valid: 1'b1, off: left_off_r,
                              size: left_size_r + tag_rdata};
            end else if (adj_r) begin
              ctl.rep     = 1'b1;
              ctl.rep_idx = pos;
              ctl.ent     = '{valid: 1'b1, off: h_r,
                              size: tag_rdata + right_size_r};
            end else if (count_r >= IDX_W'(N)) begin
              // no room for a new extent: block stays allocated
              tag_we     = 1'b0;
              dec_status = ST_FULL;
            end else begin
              ctl.ins     = 1'b1;
              ctl.mod_idx = pos;
              ctl.ent     = '{valid: 1'b1, off: h_r, size: tag_rdata};
              count_nxt   = count_r + IDX_W'(1);
            end
          end
        end
        default: begin
          dec_status = ST_DONE;
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    heap_ready_nxt = heap_ready_r || need_init;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (in_action == ACT_FREE && free_ok) begin
            state_nxt = S_TAG;
          end
        end
      end
      S_TAG: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (k_r == SCAN_W'(N - 1)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_ready_r <= 1'b0;
      count_r      <= IDX_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      heap_ready_r <= heap_ready_nxt;
      count_r      <= count_nxt;
      // immediate answers are registered at accept, others at the edit state
      out_valid_r  <= (accept && state_nxt == S_IDLE) || state_r == S_DECIDE;
    end
  end

  // payload and pass registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r         <= in_action;
      blk_r         <= in_blk;
      h_r           <= in_block_address - ADDR_W'(HEADER_BYTES);
      k_r           <= '0;
      found_r       <= 1'b0;
      left_v_r      <= 1'b0;
      right_v_r     <= 1'b0;
      ovl_r         <= 1'b0;
      out_status_r  <= ST_DONE;
      out_granted_r <= '0;
    end else if (state_r == S_SCAN) begin
      k_r <= k_r + SCAN_W'(1);
      if (head.valid) begin
        // first fit for allocate
        if (!found_r && BLK_W'(head.size) >= blk_r) begin
          found_r <= 1'b1;
          fi_r    <= IDX_W'(k_r);
          foff_r  <= head.off;
          fsize_r <= head.size;
        end
        // neighbors and overlap for free
        if (BLK_W'(h_r) < BLK_W'(head.off) + BLK_W'(head.size) &&
            BLK_W'(head.off) < BLK_W'(h_r) + BLK_W'(tag_rdata)) begin
          ovl_r <= 1'b1;
        end
        if (head.off <= h_r) begin
          left_v_r    <= 1'b1;
          left_off_r  <= head.off;
          left_size_r <= head.size;
        end else if (!right_v_r) begin
          right_v_r    <= 1'b1;
          pos_r        <= IDX_W'(k_r);
          right_off_r  <= head.off;
          right_size_r <= head.size;
        end
      end
    end else if (state_r == S_DECIDE) begin
      out_status_r  <= dec_status;
      out_granted_r <= (dec_status == ST_OK) ?
                       (foff_r + OFF_W'(HEADER_BYTES)) : '0;
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_granted_r;

endmodule
`default_nettype wire
